### rtl/rtcw_pkg.sv
// Shared types and codes for the three-wire RTC register master.
package rtcw_pkg;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [5:0] PHASE_IDLE     = 6'd0;
    localparam logic [5:0] PHASE_FIRST    = 6'd1;
    localparam logic [5:0] PHASE_CMD_LAST = 6'd16;
    localparam logic [5:0] PHASE_LAST     = 6'd33;

    localparam logic [6:0] BCD_MAX_VALUE = 7'd99;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] reg_addr;
        logic [6:0] write_value;
        logic       io_in;
    } in_item_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       data_out;
        logic       data_drive;
        logic [7:0] read_value;
        logic       done_res;
        logic       busy_res;
    } out_item_t;

    // One classified beat as handed from the front part to the sequencer.
    typedef struct packed {
        logic       is_req;
        logic       is_write;
        logic [7:0] cmd_byte;
        logic [7:0] data_byte;
        logic       io_in;
    } queue_entry_t;

endpackage

### rtl/rtcw_chan_if.sv
// Valid/ready channel interface carrying one payload per beat.
interface rtcw_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/rtcw_front.sv
// Front part: classifies an incoming beat and prepares command and BCD data bytes.
module rtcw_front
    import rtcw_pkg::*;
(
    input  in_item_t     item,
    output queue_entry_t entry
);

    // Division by ten through a reciprocal; exact for values up to 99.
    localparam logic [14:0] DIV10_MUL = 15'd205;

    logic [6:0]  value_clamped;
    logic [14:0] tens_product;
    logic [3:0]  tens;
    logic [6:0]  tens_times_ten;
    logic [6:0]  ones;
    logic        is_read;
    logic        is_write;

    always_comb
    begin
        value_clamped  = (item.write_value > BCD_MAX_VALUE) ? BCD_MAX_VALUE : item.write_value;
        tens_product   = {8'd0, value_clamped} * DIV10_MUL;
        tens           = tens_product[14:11];
        tens_times_ten = {tens, 3'b000} + {2'b00, tens, 1'b0};
        ones           = value_clamped - tens_times_ten;

        is_read  = (item.req_type == REQ_READ);
        is_write = (item.req_type == REQ_WRITE);

        entry.is_req    = is_read || is_write;
        entry.is_write  = is_write;
        entry.cmd_byte  = is_write ? item.reg_addr : item.reg_addr + 8'd1;
        entry.data_byte = is_write ? {tens, ones[3:0]} : 8'd0;
        entry.io_in     = item.io_in;
    end

endmodule

### rtl/rtcw_queue.sv
// Short queue between the front part and the sequencer.
module rtcw_queue
    import rtcw_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  queue_entry_t push_entry,
    output logic         pop_valid,
    input  logic         pop_ready,
    output queue_entry_t pop_entry
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    queue_entry_t entries_reg [DEPTH];

    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != COUNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/rtcw_back.sv
// Back part: half-bit pin sequencer with the result register.
module rtcw_back
    import rtcw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_ready,
    input  queue_entry_t q_entry,
    output logic         out_valid,
    input  logic         out_ready,
    output out_item_t    out_item
);

    logic [5:0] phase_reg;
    logic [5:0] phase_next;
    logic       is_write_reg;
    logic       is_write_next;
    logic [7:0] cmd_reg;
    logic [7:0] cmd_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       ce_reg;
    logic       ce_next;
    logic       sclk_reg;
    logic       sclk_next;
    logic       io_reg;
    logic       io_next;
    logic       drive_reg;
    logic       drive_next;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;

    logic       pop;
    logic       done;
    logic [7:0] read_value;
    logic [2:0] bit_idx;
    logic [2:0] sample_idx;

    assign q_ready   = !out_valid_reg || out_ready;
    assign pop       = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        is_write_next = is_write_reg;
        cmd_next      = cmd_reg;
        data_next     = data_reg;
        ce_next       = ce_reg;
        sclk_next     = sclk_reg;
        io_next       = io_reg;
        drive_next    = drive_reg;
        done          = 1'b0;
        read_value    = 8'd0;
        // Odd phases carry bit phase[3:1]; read sampling lags by one bit.
        bit_idx       = phase_reg[3:1];
        sample_idx    = phase_reg[3:1] - 3'd1;

        if (phase_reg == PHASE_IDLE)
        begin
            if (q_entry.is_req)
            begin
                is_write_next = q_entry.is_write;
                cmd_next      = q_entry.cmd_byte;
                data_next     = q_entry.data_byte;
                ce_next       = 1'b1;
                sclk_next     = 1'b0;
                io_next       = 1'b0;
                drive_next    = 1'b1;
                phase_next    = PHASE_FIRST;
            end
        end
        else if (phase_reg >= PHASE_LAST)
        begin
            ce_next    = 1'b0;
            sclk_next  = 1'b0;
            io_next    = 1'b0;
            drive_next = 1'b1;
            done       = 1'b1;
            if (!is_write_reg)
            begin
                read_value = {1'b0, data_reg[7:4], 3'b000} + {3'b000, data_reg[7:4], 1'b0}
                           + {4'b0000, data_reg[3:0]};
            end
            phase_next = PHASE_IDLE;
        end
        else
        begin
            if (phase_reg <= PHASE_CMD_LAST || is_write_reg)
            begin
                if (phase_reg[0])
                begin
                    ce_next    = 1'b1;
                    sclk_next  = 1'b0;
                    drive_next = 1'b1;
                    io_next    = (phase_reg <= PHASE_CMD_LAST) ? cmd_reg[bit_idx]
                                                               : data_reg[bit_idx];
                end
                else
                begin
                    sclk_next = 1'b1;
                end
            end
            else
            begin
                ce_next    = 1'b1;
                io_next    = 1'b0;
                drive_next = 1'b0;
                if (phase_reg[0])
                begin
                    sclk_next = 1'b0;
                end
                else
                begin
                    if (q_entry.io_in)
                    begin
                        data_next[sample_idx] = 1'b1;
                    end
                    // No clock pulse follows the last sample.
                    sclk_next = (sample_idx != 3'd7);
                end
            end
            phase_next = phase_reg + 6'd1;
        end

        out_item_next.chip_enable  = ce_next;
        out_item_next.serial_clock = sclk_next;
        out_item_next.data_out     = drive_next && io_next;
        out_item_next.data_drive   = drive_next;
        out_item_next.read_value   = read_value;
        out_item_next.done_res     = done;
        out_item_next.busy_res     = (phase_next != PHASE_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_IDLE;
            is_write_reg  <= 1'b0;
            cmd_reg       <= 8'd0;
            data_reg      <= 8'd0;
            ce_reg        <= 1'b0;
            sclk_reg      <= 1'b0;
            io_reg        <= 1'b0;
            drive_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg    <= phase_next;
                is_write_reg <= is_write_next;
                cmd_reg      <= cmd_next;
                data_reg     <= data_next;
                ce_reg       <= ce_next;
                sclk_reg     <= sclk_next;
                io_reg       <= io_next;
                drive_reg    <= drive_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) phase_reg <= PHASE_LAST)
        else $error("sequencer phase ran past the final step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PHASE_IDLE) |-> ce_reg)
        else $error("chip enable low during a transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        !drive_reg |-> (ce_reg && !is_write_reg && phase_reg > PHASE_CMD_LAST))
        else $error("data line released outside the read data phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.done_res) |->
            (!out_item_reg.busy_res && !out_item_reg.chip_enable))
        else $error("completion beat reports an open transaction");

endmodule

### rtl/rtc_three_wire_register_master.sv
// Top level of the three-wire RTC register master.
//
// The req channel carries one beat per tick or request: req_type selects a bus
// tick, a register read or a register write, with the register address, the decimal
// write value and the sampled IO level. The rsp channel returns exactly one beat
// per req beat, in order, with the CE, SCLK and IO pin levels after that step,
// the decimal read value and the done and busy flags.
// A request latches the command and, for a write, the BCD data; each following
// tick advances the pin sequence by one half-bit, 34 beats per transaction.
// A request that arrives while busy counts as a plain tick.
// An accepted req beat reaches its rsp beat through the queue register behind the
// classifying front end, then the sequencer step that loads the result register.
// Throughput is one beat per cycle while rsp is not stalled, set by the single
// sequencer step per cycle.
// Reset leaves the block idle with CE and SCLK low and IO driven low.
// While rsp is stalled the queue absorbs up to QUEUE_DEPTH req beats before
// req.ready drops; the result register holds its beat until taken.
module rtc_three_wire_register_master
    import rtcw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input logic         clk,
    input logic         rst_n,
    rtcw_chan_if.sink   req,
    rtcw_chan_if.source rsp
);

    queue_entry_t front_entry;
    queue_entry_t back_entry;
    in_item_t     req_item;
    out_item_t    rsp_item;
    logic         back_valid;
    logic         back_ready;
    logic         rsp_valid;

    assign req_item = req.payload;

    rtcw_front u_front (
        .item  (req_item),
        .entry (front_entry)
    );

    rtcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req.valid),
        .push_ready (req.ready),
        .push_entry (front_entry),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_entry  (back_entry)
    );

    rtcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (back_valid),
        .q_ready   (back_ready),
        .q_entry   (back_entry),
        .out_valid (rsp_valid),
        .out_ready (rsp.ready),
        .out_item  (rsp_item)
    );

    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_item;

endmodule
